### src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CLICK_W = 2;

  localparam logic [CLICK_W-1:0] CLICK_CAP = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE      = 3'd0,
    REG_SHORT_MAX     = 3'd1,
    REG_LONG_MIN      = 3'd2,
    REG_VERY_LONG_MIN = 3'd3,
    REG_CLICK_WINDOW  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SINGLE    = 3'd1,
    EV_DOUBLE    = 3'd2,
    EV_TRIPLE    = 3'd3,
    EV_LONG      = 3'd4,
    EV_VERY_LONG = 3'd5
  } ev_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST     = 16'd500;
  localparam logic [CFG_W-1:0] LONG_MIN_RST      = 16'd2000;
  localparam logic [CFG_W-1:0] VERY_LONG_MIN_RST = 16'd10000;
  localparam logic [CFG_W-1:0] CLICK_WINDOW_RST  = 16'd400;

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] short_max;
    logic [CFG_W-1:0] long_min;
    logic [CFG_W-1:0] very_long_min;
    logic [CFG_W-1:0] click_window;
  } cfg_t;

  typedef struct packed {
    ev_t               ev;
    logic              held;
    logic [TIME_W-1:0] hold_ms;
  } res_t;

endpackage

### src/bpc_cfg.sv
// ----------------------------------------------------------------------------
// bpc_cfg
// Configuration register file: five 16-bit thresholds, write only.
// ----------------------------------------------------------------------------
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce      <= DEBOUNCE_RST;
      cfg.short_max     <= SHORT_MAX_RST;
      cfg.long_min      <= LONG_MIN_RST;
      cfg.very_long_min <= VERY_LONG_MIN_RST;
      cfg.click_window  <= CLICK_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE:      cfg.debounce      <= cfg_data;
        REG_SHORT_MAX:     cfg.short_max     <= cfg_data;
        REG_LONG_MIN:      cfg.long_min      <= cfg_data;
        REG_VERY_LONG_MIN: cfg.very_long_min <= cfg_data;
        REG_CLICK_WINDOW:  cfg.click_window  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core
// Debounce and press classification state; one item per enabled cycle.
// ----------------------------------------------------------------------------
module bpc_core
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output res_t              res
);

  logic               stable_level, stable_level_next;
  logic               prev_reading;
  logic               press_active, press_active_next;
  logic [TIME_W-1:0]  press_start, press_start_next;
  logic [TIME_W-1:0]  change_time, change_time_next;
  logic [CLICK_W-1:0] click_total, click_total_next;
  logic [TIME_W-1:0]  last_click, last_click_next;
  logic               long_seen, long_seen_next;
  logic               vlong_seen, vlong_seen_next;

  logic [TIME_W-1:0]  since_change;
  logic [TIME_W-1:0]  dur;
  logic [TIME_W-1:0]  hold;
  logic [TIME_W-1:0]  since_click;
  logic               settle;
  logic               press_begin;
  logic               press_end;
  ev_t                ev;

  always_comb begin
    change_time_next  = (level != prev_reading) ? now_ms : change_time;
    since_change      = now_ms - change_time_next;
    settle            = (since_change > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce})
                        && (level != stable_level);
    stable_level_next = settle ? level : stable_level;
    press_begin       = settle && !level && !press_active;
    press_end         = settle && level && press_active;
    dur               = now_ms - press_start;

    press_active_next = press_active;
    press_start_next  = press_start;
    long_seen_next    = long_seen;
    vlong_seen_next   = vlong_seen;
    click_total_next  = click_total;
    last_click_next   = last_click;
    ev                = EV_NONE;

    if (press_begin) begin
      press_active_next = 1'b1;
      press_start_next  = now_ms;
      long_seen_next    = 1'b0;
      vlong_seen_next   = 1'b0;
    end else if (press_end) begin
      press_active_next = 1'b0;
      if (long_seen || vlong_seen) begin
        click_total_next = '0;
      end else if (dur < {{(TIME_W-CFG_W){1'b0}}, cfg.short_max}) begin
        if (click_total != CLICK_CAP) begin
          click_total_next = click_total + 1'b1;
        end
        last_click_next = now_ms;
      end
    end

    hold = press_begin ? '0 : dur;

    if (press_active_next && !vlong_seen_next && !long_seen_next) begin
      if (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.very_long_min}) begin
        vlong_seen_next  = 1'b1;
        ev               = EV_VERY_LONG;
        click_total_next = '0;
      end else if (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_min}) begin
        long_seen_next   = 1'b1;
        ev               = EV_LONG;
        click_total_next = '0;
      end
    end

    since_click = now_ms - last_click_next;
    if ((click_total_next != '0) && !press_active_next &&
        (since_click > {{(TIME_W-CFG_W){1'b0}}, cfg.click_window})) begin
      ev               = ev_t'({1'b0, click_total_next});
      click_total_next = '0;
    end

    res.ev      = ev;
    res.held    = press_active_next;
    res.hold_ms = press_active_next ? hold : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b1;
      prev_reading <= 1'b1;
      press_active <= 1'b0;
      press_start  <= '0;
      change_time  <= '0;
      click_total  <= '0;
      last_click   <= '0;
      long_seen    <= 1'b0;
      vlong_seen   <= 1'b0;
    end else if (step) begin
      stable_level <= stable_level_next;
      prev_reading <= level;
      press_active <= press_active_next;
      press_start  <= press_start_next;
      change_time  <= change_time_next;
      click_total  <= click_total_next;
      last_click   <= last_click_next;
      long_seen    <= long_seen_next;
      vlong_seen   <= vlong_seen_next;
    end
  end

endmodule

### src/button_press_classifier.sv
// An accepted input passes through the input register, then the result register.
// Throughput: one item per cycle unless out_ready stalls; the classify step is
// a single pass through the core between the input and result registers.
// Reset (rst, synchronous): thresholds return to defaults, button released,
// no press, no clicks pending, both pipeline registers empty.
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced active-low button with click, multi-click and long-press events.
// ----------------------------------------------------------------------------
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              level,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_res,
  output logic              held,
  output logic [TIME_W-1:0] hold_ms
);

  cfg_t              cfg;
  res_t              res;
  logic              iv;
  logic              lvl_q;
  logic [TIME_W-1:0] now_q;
  logic              adv;
  logic              step;

  assign adv      = !out_valid || out_ready;
  assign step     = iv && adv;
  assign in_ready = !iv || adv;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .level  (lvl_q),
    .now_ms (now_q),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lvl_q <= level;
      now_q <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_res <= res.ev;
      held      <= res.held;
      hold_ms   <= res.hold_ms;
    end
  end

`ifndef SYNTHESIS
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !held |-> hold_ms == '0)
    else $error("hold time nonzero while released");

  a_long_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_LONG || event_res == EV_VERY_LONG) |-> held)
    else $error("hold event while released");

  a_click_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_SINGLE || event_res == EV_DOUBLE ||
                  event_res == EV_TRIPLE) |-> !held)
    else $error("click event while pressed");

  a_in_loaded: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> iv)
    else $error("accepted item not loaded");
`endif

endmodule

### tb/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Watches the config port and both item channels of the button press
// classifier, predicts every result item from its own copy of the debounce,
// press and click state, and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module bpc_checker
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              level,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        event_res,
  input  logic              held,
  input  logic [TIME_W-1:0] hold_ms,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t              cfg;
  logic              stable_lvl;
  logic              prev_lvl;
  logic              pressed;
  logic              long_hit;
  logic              vlong_hit;
  logic [TIME_W-1:0] press_t0;
  logic [TIME_W-1:0] change_t;
  logic [TIME_W-1:0] last_click_t;
  logic [CLICK_W-1:0] clicks;

  res_t report_q[$];
  int   err_cnt = 0;

  function automatic res_t classify_sample(input logic lvl, input logic [TIME_W-1:0] now);
    res_t              r;
    ev_t               ev;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] quiet;
    ev = EV_NONE;
    if (lvl != prev_lvl) change_t = now;
    since_change = now - change_t;
    if (since_change > TIME_W'(cfg.debounce) && lvl != stable_lvl) begin
      stable_lvl = lvl;
      if (!stable_lvl && !pressed) begin
        pressed   = 1'b1;
        press_t0  = now;
        long_hit  = 1'b0;
        vlong_hit = 1'b0;
      end else if (stable_lvl && pressed) begin
        dur     = now - press_t0;
        pressed = 1'b0;
        if (vlong_hit || long_hit) begin
          clicks = '0;
        end else if (dur < TIME_W'(cfg.short_max)) begin
          if (clicks != CLICK_CAP) clicks = clicks + 1'b1;
          last_click_t = now;
        end
      end
    end
    if (pressed && !vlong_hit && !long_hit) begin
      dur = now - press_t0;
      // very long is checked first
      if (dur >= TIME_W'(cfg.very_long_min)) begin
        vlong_hit = 1'b1;
        ev        = EV_VERY_LONG;
        clicks    = '0;
      end else if (dur >= TIME_W'(cfg.long_min)) begin
        long_hit = 1'b1;
        ev       = EV_LONG;
        clicks   = '0;
      end
    end
    quiet = now - last_click_t;
    if (clicks != '0 && !pressed && quiet > TIME_W'(cfg.click_window)) begin
      ev     = ev_t'({1'b0, clicks});
      clicks = '0;
    end
    prev_lvl  = lvl;
    r.ev      = ev;
    r.held    = pressed;
    r.hold_ms = pressed ? now - press_t0 : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cfg.debounce      = DEBOUNCE_RST;
      cfg.short_max     = SHORT_MAX_RST;
      cfg.long_min      = LONG_MIN_RST;
      cfg.very_long_min = VERY_LONG_MIN_RST;
      cfg.click_window  = CLICK_WINDOW_RST;
      stable_lvl   = 1'b1;
      prev_lvl     = 1'b1;
      pressed      = 1'b0;
      long_hit     = 1'b0;
      vlong_hit    = 1'b0;
      press_t0     = '0;
      change_t     = '0;
      last_click_t = '0;
      clicks       = '0;
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:      cfg.debounce      = cfg_data;
          REG_SHORT_MAX:     cfg.short_max     = cfg_data;
          REG_LONG_MIN:      cfg.long_min      = cfg_data;
          REG_VERY_LONG_MIN: cfg.very_long_min = cfg_data;
          REG_CLICK_WINDOW:  cfg.click_window  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) report_q.push_back(classify_sample(level, now_ms));
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: result item with nothing expected: event %0d held %0b hold_ms %0d",
                   $time, event_res, held, hold_ms);
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          if (event_res !== want.ev) begin
            $display("%0t: event_res expected %0d got %0d", $time, want.ev, event_res);
            err_cnt++;
          end
          if (held !== want.held) begin
            $display("%0t: held expected %0b got %0b", $time, want.held, held);
            err_cnt++;
          end
          if (hold_ms !== want.hold_ms) begin
            $display("%0t: hold_ms expected %0d got %0d", $time, want.hold_ms, hold_ms);
            err_cnt++;
          end
        end
      end
    end
    pending <= report_q.size();
    errors  <= err_cnt;
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the button press classifier with directed press/click sequences,
// then randomized bouncing press and release runs plus noise under several
// threshold settings and idle patterns; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top;
  import bpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               CYCLE_LIMIT     = 300000;
  localparam int               HOLD_OFF_CYCLES = 64;
  localparam int               PHASE_ITEMS     = 235;
  localparam logic [IDX_W-1:0] REG_UNUSED_5    = 3'd5;
  localparam logic [IDX_W-1:0] REG_UNUSED_7    = 3'd7;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              level     = 1'b1;
  logic [TIME_W-1:0] now_ms    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        event_res;
  logic              held;
  logic [TIME_W-1:0] hold_ms;

  int errors;
  int pending;

  int snd_idle     = 0;
  int rcv_stall    = 0;
  int hold_off_req = 0;
  int hold_off_ack = 0;
  int hold_left    = 0;
  int cycles       = 0;
  int sent         = 0;

  logic [TIME_W-1:0] t = '0;
  cfg_t              cur;

  button_press_classifier uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .level, .now_ms,
    .out_valid, .out_ready, .event_res, .held, .hold_ms
  );

  bpc_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .level, .now_ms,
    .out_valid, .out_ready, .event_res, .held, .hold_ms,
    .errors, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_ack != hold_off_req) begin
      hold_off_ack <= hold_off_req;
      hold_left    <= HOLD_OFF_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  task automatic send(input logic lvl, input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    level    <= lvl;
    now_ms   <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic step(input logic lvl, input int unsigned dt);
    t += dt;
    send(lvl, t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_DEBOUNCE, c.debounce);
    write_reg(REG_SHORT_MAX, c.short_max);
    write_reg(REG_LONG_MIN, c.long_min);
    write_reg(REG_VERY_LONG_MIN, c.very_long_min);
    write_reg(REG_CLICK_WINDOW, c.click_window);
    cfg_we <= 1'b0;
    cur = c;
  endtask

  // one stretch of a level lasting more than len ms, optionally with bounce
  task automatic level_run(input logic lvl, input int unsigned len);
    int unsigned n;
    int unsigned stride;
    t += $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send(lvl, t);
        t += $urandom_range(0, cur.debounce / 2);
        send(!lvl, t);
        t += $urandom_range(0, cur.debounce / 2);
      end
    end
    n      = $urandom_range(1, 6);
    stride = len / n + 1;
    send(lvl, t);
    repeat (n) step(lvl, stride + $urandom_range(0, stride / 4));
  endtask

  task automatic press_and_release();
    int unsigned d;
    int unsigned gap;
    case ($urandom_range(0, 5))
      0, 1, 2: d = $urandom_range(0, cur.short_max);
      3:       d = $urandom_range(cur.short_max, cur.long_min);
      4:       d = $urandom_range(cur.long_min, cur.very_long_min);
      default: d = cur.very_long_min + $urandom_range(0, cur.very_long_min / 2 + 10);
    endcase
    level_run(1'b0, cur.debounce + 1 + d);
    if ($urandom_range(0, 4) < 3) gap = $urandom_range(0, cur.click_window);
    else gap = cur.click_window + $urandom_range(1, cur.click_window + 10);
    level_run(1'b1, cur.debounce + 1 + gap);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 3))
        0:       t += $urandom_range(0, 3);
        1:       t += $urandom_range(0, 2 * cur.debounce + 2);
        2:       t += $urandom();
        default: t = $urandom();
      endcase
      send(1'($urandom_range(0, 1)), t);
    end
  endtask

  function automatic cfg_t small_cfg();
    cfg_t c;
    c.debounce      = CFG_W'($urandom_range(0, 8));
    c.short_max     = CFG_W'($urandom_range(10, 60));
    c.long_min      = CFG_W'($urandom_range(60, 150));
    c.very_long_min = CFG_W'($urandom_range(100, 300));
    c.click_window  = CFG_W'($urandom_range(10, 60));
    return c;
  endfunction

  task automatic run_phase(input cfg_t c, input int snd, input int rcv, input bit wrap,
                           input bit pressure);
    int  first;
    bit  paused;
    drain();
    repeat (4) @(posedge clk);
    load_cfg(c);
    snd_idle  = snd;
    rcv_stall <= rcv;
    if (wrap) t = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    if (pressure) hold_off_req <= hold_off_req + 1;
    first  = sent;
    paused = 1'b0;
    while (sent - first < PHASE_ITEMS) begin
      if (pressure && !paused && sent - first >= PHASE_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) noise_burst();
      else press_and_release();
    end
  endtask

  initial begin
    cfg_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    cur.debounce      = DEBOUNCE_RST;
    cur.short_max     = SHORT_MAX_RST;
    cur.long_min      = LONG_MIN_RST;
    cur.very_long_min = VERY_LONG_MIN_RST;
    cur.click_window  = CLICK_WINDOW_RST;

    // unmapped indexes must not disturb the thresholds
    write_reg(REG_UNUSED_5, 16'h0001);
    write_reg(REG_UNUSED_7, 16'h0001);
    cfg_we <= 1'b0;

    // four clicks saturate at a triple; time wraps to zero on the first item
    t = 32'hFFFF_FFFF;
    repeat (4) begin
      step(1'b0, 1);
      step(1'b0, 51);
      step(1'b1, 99);
      step(1'b1, 51);
    end
    step(1'b1, 401);
    // medium press: no event, no click
    step(1'b0, 10);
    step(1'b0, 51);
    step(1'b1, 1000);
    step(1'b1, 51);
    // long press, no very long afterwards, release clears clicks
    step(1'b0, 10);
    step(1'b0, 51);
    step(1'b0, 2000);
    step(1'b0, 8000);
    step(1'b1, 10);
    step(1'b1, 51);

    run_phase(small_cfg(), 0, 0, 1'b0, 1'b0);
    run_phase(small_cfg(), 69, 0, 1'b0, 1'b0);
    c = '0;
    run_phase(c, 0, 69, 1'b0, 1'b0);
    c = '1;
    run_phase(c, 31, 31, 1'b1, 1'b0);
    c.debounce      = CFG_W'($urandom_range(0, 65535));
    c.short_max     = CFG_W'($urandom_range(0, 65535));
    c.long_min      = CFG_W'($urandom_range(0, 65535));
    c.very_long_min = CFG_W'($urandom_range(0, 65535));
    c.click_window  = CFG_W'($urandom_range(0, 65535));
    run_phase(c, 31, 31, 1'b0, 1'b0);
    c.debounce      = DEBOUNCE_RST;
    c.short_max     = SHORT_MAX_RST;
    c.long_min      = LONG_MIN_RST;
    c.very_long_min = VERY_LONG_MIN_RST;
    c.click_window  = CLICK_WINDOW_RST;
    run_phase(c, 0, 0, 1'b1, 1'b1);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/bpc_pkg.sv
src/bpc_cfg.sv
src/bpc_core.sv
src/button_press_classifier.sv
tb/bpc_checker.sv
tb/tb_top.sv
